### rtl/atd_pkg.sv
// types, constants and helpers shared by the tilt decoder modules
// no dependencies
package atd_pkg;

  localparam int AccW      = 10;  // raw accelerometer width
  localparam int D2W       = 21;  // b*b + c*c
  localparam int FracBits  = 32;  // d2 scaled by 2^32 before the root
  localparam int SqrtSteps = 27;  // one root bit per cell
  localparam int RootW     = 27;
  localparam int RemW      = 31;
  localparam int XyW       = 30;  // cordic x/y, signed
  localparam int ZW        = 32;  // angle accumulator, signed
  localparam int AngW      = 14;
  localparam int AtanLen   = 24;
  localparam int IdxW      = 5;

  localparam logic [AngW-1:0] RightAngle = 14'd9000;
  localparam logic signed [ZW-1:0] RoundHalf = 32'sd32768;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [D2W-1:0]   d2;
    logic [AccW-1:0]  n;
  } sqrt_lane_t;

  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
    logic                  zero_den;
    logic                  num_nz;
  } cordic_lane_t;

  typedef struct packed {
    logic [7:0]      stick_x;
    logic [7:0]      stick_y;
    logic [AccW-1:0] accel_x;
    logic [AccW-1:0] accel_y;
    logic [AccW-1:0] accel_z;
    logic            button_c;
    logic            button_z;
  } side_t;

  // atan(2^-i) in units of 2^-16 centidegree
  function automatic logic signed [ZW-1:0] atan_entry(input logic [IdxW-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 32'sd294912000;
      5'd1:    v = 32'sd174096719;
      5'd2:    v = 32'sd91987925;
      5'd3:    v = 32'sd46694507;
      5'd4:    v = 32'sd23437865;
      5'd5:    v = 32'sd11730358;
      5'd6:    v = 32'sd5866610;
      5'd7:    v = 32'sd2933484;
      5'd8:    v = 32'sd1466764;
      5'd9:    v = 32'sd733385;
      5'd10:   v = 32'sd366693;
      5'd11:   v = 32'sd183346;
      5'd12:   v = 32'sd91673;
      5'd13:   v = 32'sd45837;
      5'd14:   v = 32'sd22918;
      5'd15:   v = 32'sd11459;
      5'd16:   v = 32'sd5730;
      5'd17:   v = 32'sd2865;
      5'd18:   v = 32'sd1432;
      5'd19:   v = 32'sd716;
      5'd20:   v = 32'sd358;
      5'd21:   v = 32'sd179;
      5'd22:   v = 32'sd90;
      5'd23:   v = 32'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round the accumulator to centidegrees and clamp, with degenerate cases
  function automatic logic [AngW-1:0] angle_round(input cordic_lane_t l);
    logic signed [ZW-1:0] zr;
    logic [AngW-1:0]      r;
    zr = (l.z + RoundHalf) >>> 16;
    if (l.zero_den) begin
      r = l.num_nz ? RightAngle : '0;
    end else if (l.z[ZW-1]) begin
      r = '0;
    end else if (zr > $signed({{(ZW-AngW){1'b0}}, RightAngle})) begin
      r = RightAngle;
    end else begin
      r = zr[AngW-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/atd_if.sv
// report and result channels of the tilt decoder
// no dependencies
interface atd_report_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;
  modport source (output valid, byte0, byte1, byte2, byte3, byte4, byte5, input ready);
  modport sink   (input valid, byte0, byte1, byte2, byte3, byte4, byte5, output ready);
endinterface

interface atd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  stick_x;
  logic [7:0]  stick_y;
  logic [9:0]  accel_x;
  logic [9:0]  accel_y;
  logic [9:0]  accel_z;
  logic        button_c;
  logic        button_z;
  logic [13:0] roll_centideg;
  logic [13:0] pitch_centideg;
  modport source (output valid, stick_x, stick_y, accel_x, accel_y, accel_z, button_c,
                  button_z, roll_centideg, pitch_centideg, input ready);
  modport sink   (input valid, stick_x, stick_y, accel_x, accel_y, accel_z, button_c,
                  button_z, roll_centideg, pitch_centideg, output ready);
endinterface

### rtl/atd_sqrt_cell.sv
// one digit cell of the pipelined integer square root
// depends on atd_pkg
module atd_sqrt_cell #(
  parameter int Step = 0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  atd_pkg::sqrt_lane_t lane_i,
  output atd_pkg::sqrt_lane_t lane_o
);
  import atd_pkg::*;

  logic [2*SqrtSteps-1:0] radicand;
  logic [1:0]             pair;
  logic [RemW-1:0]        rem_s;
  logic [RemW-1:0]        trial;
  sqrt_lane_t             lane_d;
  sqrt_lane_t             lane_q;

  always_comb begin
    radicand = {{(2*SqrtSteps-D2W-FracBits){1'b0}}, lane_i.d2, {FracBits{1'b0}}};
    pair     = radicand[2*Step +: 2];
    rem_s    = {lane_i.rem[RemW-3:0], pair};
    trial    = {2'b00, lane_i.root, 2'b01};
    lane_d   = lane_i;
    if (rem_s >= trial) begin
      lane_d.rem  = rem_s - trial;
      lane_d.root = {lane_i.root[RootW-2:0], 1'b1};
    end else begin
      lane_d.rem  = rem_s;
      lane_d.root = {lane_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

### rtl/atd_cordic_cell.sv
// one rotation cell of the vectoring cordic
// depends on atd_pkg
module atd_cordic_cell #(
  parameter int Idx = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  atd_pkg::cordic_lane_t lane_i,
  output atd_pkg::cordic_lane_t lane_o
);
  import atd_pkg::*;

  logic signed [XyW-1:0] xs;
  logic signed [XyW-1:0] ys;
  cordic_lane_t          lane_d;
  cordic_lane_t          lane_q;

  always_comb begin
    xs     = lane_i.x >>> Idx;
    ys     = lane_i.y >>> Idx;
    lane_d = lane_i;
    if (!lane_i.y[XyW-1]) begin
      lane_d.x = lane_i.x + ys;
      lane_d.y = lane_i.y - xs;
      lane_d.z = lane_i.z + atan_entry(IdxW'(Idx));
    end else begin
      lane_d.x = lane_i.x - ys;
      lane_d.y = lane_i.y + xs;
      lane_d.z = lane_i.z - atan_entry(IdxW'(Idx));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

### rtl/accel_report_tilt_decoder_unit.sv
// tilt decoder top level: report decode, squares, root cells, cordic cells, output register
// depends on atd_pkg, atd_if, atd_sqrt_cell, atd_cordic_cell
// a report passes the squares register, the root cells, the cordic cells and the output register
// throughput: one report per cycle; the whole pipe advances unless the result waits
// the stall is set by the output register: the pipe holds while a result is not taken
// reset clears the valid bits of every stage and the output; payload is not reset
module accel_report_tilt_decoder_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  atd_report_if.sink  report_i,
  atd_result_if.source result_o
);
  import atd_pkg::*;

  // stages before the output register: squares, root cells, cordic cells
  localparam int Depth = 1 + SqrtSteps + CORDIC_STAGES;

  logic             en;
  logic [Depth-1:0] vld_q;
  logic             out_vld_q;
  side_t            side_q [Depth];
  side_t            side_in;
  side_t            out_side_q;
  logic [AngW-1:0]  roll_q;
  logic [AngW-1:0]  pitch_q;

  sqrt_lane_t   roll_sq0_q;
  sqrt_lane_t   pitch_sq0_q;
  cordic_lane_t roll_cd0;
  cordic_lane_t pitch_cd0;

  sqrt_lane_t   roll_sq  [SqrtSteps+1];
  sqrt_lane_t   pitch_sq [SqrtSteps+1];
  cordic_lane_t roll_cd  [CORDIC_STAGES+1];
  cordic_lane_t pitch_cd [CORDIC_STAGES+1];

  // whole pipe moves when the output slot is free or being taken
  assign en             = !out_vld_q || result_o.ready;
  assign report_i.ready = en;

  // field decode
  always_comb begin
    side_in.stick_x  = report_i.byte0;
    side_in.stick_y  = report_i.byte1;
    side_in.accel_x  = {report_i.byte2, report_i.byte5[3:2]};
    side_in.accel_y  = {report_i.byte3, report_i.byte5[5:4]};
    side_in.accel_z  = {report_i.byte4, report_i.byte5[7:6]};
    side_in.button_c = !report_i.byte5[1];
    side_in.button_z = !report_i.byte5[0];
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[Depth-2:0], report_i.valid};
      out_vld_q <= vld_q[Depth-1];
    end
  end

  // first stage: squared sums of the two other axes for each angle
  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_sq0_q.rem   <= '0;
      roll_sq0_q.root  <= '0;
      roll_sq0_q.d2    <= D2W'(side_in.accel_x) * D2W'(side_in.accel_x)
                        + D2W'(side_in.accel_z) * D2W'(side_in.accel_z);
      roll_sq0_q.n     <= side_in.accel_y;
      pitch_sq0_q.rem  <= '0;
      pitch_sq0_q.root <= '0;
      pitch_sq0_q.d2   <= D2W'(side_in.accel_y) * D2W'(side_in.accel_y)
                        + D2W'(side_in.accel_z) * D2W'(side_in.accel_z);
      pitch_sq0_q.n    <= side_in.accel_x;
    end
  end

  assign roll_sq[0]  = roll_sq0_q;
  assign pitch_sq[0] = pitch_sq0_q;

  // side fields ride along with the angle lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k < Depth; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // root cells, most significant digit first
  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    atd_sqrt_cell #(.Step(SqrtSteps - 1 - g)) u_roll_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (roll_sq[g]),
      .lane_o (roll_sq[g+1])
    );
    atd_sqrt_cell #(.Step(SqrtSteps - 1 - g)) u_pitch_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (pitch_sq[g]),
      .lane_o (pitch_sq[g+1])
    );
  end

  // root becomes x, numerator scaled by 2^16 becomes y
  always_comb begin
    roll_cd0.x         = $signed({{(XyW-RootW){1'b0}}, roll_sq[SqrtSteps].root});
    roll_cd0.y         = $signed({{(XyW-AccW-16){1'b0}}, roll_sq[SqrtSteps].n, 16'h0000});
    roll_cd0.z         = '0;
    roll_cd0.zero_den  = (roll_sq[SqrtSteps].d2 == '0);
    roll_cd0.num_nz    = (roll_sq[SqrtSteps].n != '0);
    pitch_cd0.x        = $signed({{(XyW-RootW){1'b0}}, pitch_sq[SqrtSteps].root});
    pitch_cd0.y        = $signed({{(XyW-AccW-16){1'b0}}, pitch_sq[SqrtSteps].n, 16'h0000});
    pitch_cd0.z        = '0;
    pitch_cd0.zero_den = (pitch_sq[SqrtSteps].d2 == '0);
    pitch_cd0.num_nz   = (pitch_sq[SqrtSteps].n != '0);
  end

  assign roll_cd[0]  = roll_cd0;
  assign pitch_cd[0] = pitch_cd0;

  // cordic cells, one shift amount each
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    atd_cordic_cell #(.Idx(g)) u_roll_cordic (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (roll_cd[g]),
      .lane_o (roll_cd[g+1])
    );
    atd_cordic_cell #(.Idx(g)) u_pitch_cordic (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (pitch_cd[g]),
      .lane_o (pitch_cd[g+1])
    );
  end

  // output register: rounding, clamp and degenerate cases
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_side_q <= side_q[Depth-1];
      roll_q     <= angle_round(roll_cd[CORDIC_STAGES]);
      pitch_q    <= angle_round(pitch_cd[CORDIC_STAGES]);
    end
  end

  assign result_o.valid          = out_vld_q;
  assign result_o.stick_x        = out_side_q.stick_x;
  assign result_o.stick_y        = out_side_q.stick_y;
  assign result_o.accel_x        = out_side_q.accel_x;
  assign result_o.accel_y        = out_side_q.accel_y;
  assign result_o.accel_z        = out_side_q.accel_z;
  assign result_o.button_c       = out_side_q.button_c;
  assign result_o.button_z       = out_side_q.button_z;
  assign result_o.roll_centideg  = roll_q;
  assign result_o.pitch_centideg = pitch_q;

endmodule

### rtl/atd_checker.sv
// port-level checks of the tilt decoder and the bind that attaches them
// depends on accel_report_tilt_decoder_unit
module atd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [9:0]  accel_x_i,
  input logic [9:0]  accel_y_i,
  input logic [9:0]  accel_z_i,
  input logic [13:0] roll_i,
  input logic [13:0] pitch_i
);

  // a waiting result stays until transferred
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> roll_i <= 14'd9000)
    else $error("roll above right angle");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pitch_i <= 14'd9000)
    else $error("pitch above right angle");

  // all axes zero gives zero angles
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && accel_x_i == 10'd0 && accel_y_i == 10'd0 && accel_z_i == 10'd0
      |-> roll_i == 14'd0 && pitch_i == 14'd0)
    else $error("nonzero angle for zero acceleration");

endmodule

bind accel_report_tilt_decoder_unit atd_checker u_atd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .accel_x_i   (result_o.accel_x),
  .accel_y_i   (result_o.accel_y),
  .accel_z_i   (result_o.accel_z),
  .roll_i      (result_o.roll_centideg),
  .pitch_i     (result_o.pitch_centideg)
);
